// ===== design/sqltp_pkg.sv =====
package sqltp_pkg;

  localparam int KindWidth   = 5;
  localparam int TagWidth    = 16;
  localparam int RoleWidth   = 3;
  localparam int RelWidth    = 2;
  localparam int QueryWidth  = 3;
  localparam int StatusWidth = 2;
  localparam int InDataWidth  = 32;
  localparam int OutDataWidth = 32;

  typedef logic [KindWidth-1:0]   kind_t;
  typedef logic [TagWidth-1:0]    tag_t;
  typedef logic [RoleWidth-1:0]   role_t;
  typedef logic [RelWidth-1:0]    rel_t;
  typedef logic [QueryWidth-1:0]  query_t;
  typedef logic [StatusWidth-1:0] status_t;

  localparam kind_t K_EOS     = 5'd0;
  localparam kind_t K_INSERT  = 5'd1;
  localparam kind_t K_SELECT  = 5'd2;
  localparam kind_t K_UPDATE  = 5'd3;
  localparam kind_t K_CREATE  = 5'd4;
  localparam kind_t K_INTO    = 5'd5;
  localparam kind_t K_VALUES  = 5'd6;
  localparam kind_t K_TABLE   = 5'd7;
  localparam kind_t K_SET     = 5'd8;
  localparam kind_t K_WHERE   = 5'd9;
  localparam kind_t K_FROM    = 5'd10;
  localparam kind_t K_ORDER   = 5'd11;
  localparam kind_t K_BY      = 5'd12;
  localparam kind_t K_TRUE    = 5'd13;
  localparam kind_t K_FALSE   = 5'd14;
  localparam kind_t K_LPAREN  = 5'd15;
  localparam kind_t K_RPAREN  = 5'd16;
  localparam kind_t K_COMMA   = 5'd17;
  localparam kind_t K_STAR    = 5'd18;
  localparam kind_t K_LESS    = 5'd19;
  localparam kind_t K_GREATER = 5'd20;
  localparam kind_t K_EQUAL   = 5'd21;
  localparam kind_t K_ID      = 5'd22;
  localparam kind_t K_NUMBER  = 5'd23;
  localparam kind_t K_STRING  = 5'd24;

  localparam role_t ROLE_NONE     = 3'd0;
  localparam role_t ROLE_TABLE    = 3'd1;
  localparam role_t ROLE_COLUMN   = 3'd2;
  localparam role_t ROLE_VALUE    = 3'd3;
  localparam role_t ROLE_WH_FIELD = 3'd4;
  localparam role_t ROLE_WH_OP    = 3'd5;
  localparam role_t ROLE_WH_VALUE = 3'd6;
  localparam role_t ROLE_ORDER    = 3'd7;

  localparam rel_t REL_NONE    = 2'd0;
  localparam rel_t REL_LESS    = 2'd1;
  localparam rel_t REL_GREATER = 2'd2;
  localparam rel_t REL_EQUAL   = 2'd3;

  localparam query_t Q_NONE   = 3'd0;
  localparam query_t Q_INSERT = 3'd1;
  localparam query_t Q_SELECT = 3'd2;
  localparam query_t Q_UPDATE = 3'd3;
  localparam query_t Q_CREATE = 3'd4;

  localparam status_t ST_BUSY       = 2'd0;
  localparam status_t ST_OK         = 2'd1;
  localparam status_t ST_ERROR      = 2'd2;
  localparam status_t ST_INCOMPLETE = 2'd3;

  typedef enum logic [35:0] {
    S_START     = 36'd1 << 0,
    S_DONE      = 36'd1 << 1,
    S_FAIL      = 36'd1 << 2,
    S_CR_TABLE  = 36'd1 << 3,
    S_CR_NAME   = 36'd1 << 4,
    S_CR_LP     = 36'd1 << 5,
    S_CR_FIELD  = 36'd1 << 6,
    S_CR_SEP    = 36'd1 << 7,
    S_UP_TABLE  = 36'd1 << 8,
    S_UP_SET    = 36'd1 << 9,
    S_UP_FIELD  = 36'd1 << 10,
    S_UP_EQ     = 36'd1 << 11,
    S_UP_VALUE  = 36'd1 << 12,
    S_UP_SEP    = 36'd1 << 13,
    S_SE_FIELD  = 36'd1 << 14,
    S_SE_COMMA  = 36'd1 << 15,
    S_SE_FROM   = 36'd1 << 16,
    S_SE_TABLE  = 36'd1 << 17,
    S_ORD       = 36'd1 << 18,
    S_ORD_BY    = 36'd1 << 19,
    S_ORD_FIELD = 36'd1 << 20,
    S_WH_KEYWORD = 36'd1 << 21,
    S_WH_FIELD  = 36'd1 << 22,
    S_WH_OP     = 36'd1 << 23,
    S_WH_VALUE  = 36'd1 << 24,
    S_WH_AND    = 36'd1 << 25,
    S_IN_INTO   = 36'd1 << 26,
    S_IN_NAME   = 36'd1 << 27,
    S_IN_LP     = 36'd1 << 28,
    S_IN_FIELD  = 36'd1 << 29,
    S_IN_FSEP   = 36'd1 << 30,
    S_IN_VKW    = 36'd1 << 31,
    S_IN_VLP    = 36'd1 << 32,
    S_IN_VAL    = 36'd1 << 33,
    S_IN_VSEP   = 36'd1 << 34,
    S_IN_ROWLP  = 36'd1 << 35
  } step_t;

  typedef struct packed {
    step_t   step_next;
    query_t  qkind_next;
    role_t   token_role;
    rel_t    relation_op;
    query_t  query_kind;
    status_t parse_status;
  } dec_t;

endpackage

// ===== design/sql_statement_token_parser_top.sv =====
// SQL statement token parser. A lexer sends one token word per cycle on the s_ channel:
// the token kind, the kind of the following token and a tag for the token text. For
// every token word exactly one result word leaves on the m_ channel, in order: the
// token's role, the where operator, the query kind, the parse status and the tag.
// The first token picks INSERT, SELECT, UPDATE or CREATE; an end-of-stream token
// reports the final status and returns the parser to statement start.
// A word waits in the input register while the parser state machine classifies it,
// and the result is written to the output register when the word advances, so a
// result passes the input register and then the output register on its way to m_.
// One word per cycle is sustained while the receiver keeps m_tready high; the single
// state transition per token sets that figure.
// When the receiver stalls, the output register holds its word and the input
// register fills; s_tready falls only when both are occupied and m_tready is low.
// Reset empties both registers and puts the parser at statement start with no query
// kind.
module sql_statement_token_parser_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // token_kind [4:0], next_kind [9:5], token_tag [25:10], zero [31:26]
  input  logic [sqltp_pkg::InDataWidth-1:0]  s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // token_role [2:0], relation_op [4:3], query_kind [7:5], parse_status [9:8],
  // tag_out [25:10], zero [31:26]
  output logic [sqltp_pkg::OutDataWidth-1:0] m_tdata
);

  logic               in_valid;
  sqltp_pkg::kind_t   in_kind;
  sqltp_pkg::kind_t   in_next;
  sqltp_pkg::tag_t    in_tag;
  logic               advance;

  sqltp_pkg::step_t   step;
  sqltp_pkg::query_t  qkind;
  sqltp_pkg::dec_t    dec;

  logic               out_valid;
  sqltp_pkg::dec_t    out_dec;
  sqltp_pkg::tag_t    out_tag;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tdata[4:0];
      in_next <= s_tdata[9:5];
      in_tag  <= s_tdata[25:10];
    end
  end

  sqltp_decode u_decode (
    .step       (step),
    .qkind      (qkind),
    .token_kind (in_kind),
    .next_kind  (in_next),
    .dec        (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= sqltp_pkg::S_START;
      qkind <= sqltp_pkg::Q_NONE;
    end else if (advance) begin
      step  <= dec.step_next;
      qkind <= dec.qkind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_dec <= dec;
      out_tag <= in_tag;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_tag, out_dec.parse_status, out_dec.query_kind,
                     out_dec.relation_op, out_dec.token_role};

`ifndef NO_ASSERTIONS
  a_eos_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && in_kind == sqltp_pkg::K_EOS |=>
      step == sqltp_pkg::S_START && qkind == sqltp_pkg::Q_NONE)
    else $error("parser did not return to statement start after end of stream");

  a_rel_only_on_op: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_dec.relation_op != sqltp_pkg::REL_NONE |->
      out_dec.token_role == sqltp_pkg::ROLE_WH_OP)
    else $error("relation operator reported on a token that is not a where operator");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !m_tready |-> !s_tready)
    else $error("input accepted while both registers are full and the output stalls");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(step) && $stable(qkind))
    else $error("parser state changed without a word being classified");
`endif

endmodule

// ===== design/sqltp_decode.sv =====
module sqltp_decode (
  input  sqltp_pkg::step_t  step,
  input  sqltp_pkg::query_t qkind,
  input  sqltp_pkg::kind_t  token_kind,
  input  sqltp_pkg::kind_t  next_kind,
  output sqltp_pkg::dec_t   dec
);

  sqltp_pkg::step_t   s;
  sqltp_pkg::query_t  q;
  sqltp_pkg::role_t   role;
  sqltp_pkg::rel_t    rel;
  sqltp_pkg::status_t status;
  logic               k_id;

  assign k_id = (token_kind == sqltp_pkg::K_ID);

  always_comb begin
    s      = step;
    q      = qkind;
    role   = sqltp_pkg::ROLE_NONE;
    rel    = sqltp_pkg::REL_NONE;
    status = sqltp_pkg::ST_BUSY;
    if (token_kind == sqltp_pkg::K_EOS) begin
      if (step == sqltp_pkg::S_DONE || step == sqltp_pkg::S_UP_SEP ||
          step == sqltp_pkg::S_WH_AND) begin
        status = sqltp_pkg::ST_OK;
      end else if (step == sqltp_pkg::S_FAIL) begin
        status = sqltp_pkg::ST_ERROR;
      end else begin
        status = sqltp_pkg::ST_INCOMPLETE;
      end
      s = sqltp_pkg::S_START;
      q = sqltp_pkg::Q_NONE;
    end else begin
      unique case (step)
        sqltp_pkg::S_START: begin
          priority if (token_kind == sqltp_pkg::K_INSERT) begin
            q = sqltp_pkg::Q_INSERT;
            s = sqltp_pkg::S_IN_INTO;
          end else if (token_kind == sqltp_pkg::K_SELECT) begin
            q = sqltp_pkg::Q_SELECT;
            s = sqltp_pkg::S_SE_FIELD;
          end else if (token_kind == sqltp_pkg::K_UPDATE) begin
            q = sqltp_pkg::Q_UPDATE;
            s = sqltp_pkg::S_UP_TABLE;
          end else if (token_kind == sqltp_pkg::K_CREATE) begin
            q = sqltp_pkg::Q_CREATE;
            s = sqltp_pkg::S_CR_TABLE;
          end else begin
            s = sqltp_pkg::S_FAIL;
          end
        end
        sqltp_pkg::S_DONE, sqltp_pkg::S_FAIL: begin
          s = step;
        end
        sqltp_pkg::S_CR_TABLE: begin
          s = (token_kind == sqltp_pkg::K_TABLE) ? sqltp_pkg::S_CR_NAME : sqltp_pkg::S_FAIL;
        end
        sqltp_pkg::S_CR_NAME: begin
          s    = k_id ? sqltp_pkg::S_CR_LP : sqltp_pkg::S_FAIL;
          role = k_id ? sqltp_pkg::ROLE_TABLE : sqltp_pkg::ROLE_NONE;
        end
        sqltp_pkg::S_CR_LP: begin
          s = (token_kind == sqltp_pkg::K_LPAREN) ? sqltp_pkg::S_CR_FIELD : sqltp_pkg::S_FAIL;
        end
        sqltp_pkg::S_CR_FIELD: begin
          s    = k_id ? sqltp_pkg::S_CR_SEP : sqltp_pkg::S_FAIL;
          role = k_id ? sqltp_pkg::ROLE_COLUMN : sqltp_pkg::ROLE_NONE;
        end
        sqltp_pkg::S_CR_SEP: begin
          priority if (token_kind == sqltp_pkg::K_RPAREN) begin
            s = sqltp_pkg::S_DONE;
          end else if (token_kind == sqltp_pkg::K_COMMA) begin
            s = sqltp_pkg::S_CR_FIELD;
          end else begin
            s = sqltp_pkg::S_FAIL;
          end
        end
        sqltp_pkg::S_UP_TABLE: begin
          s    = k_id ? sqltp_pkg::S_UP_SET : sqltp_pkg::S_FAIL;
          role = k_id ? sqltp_pkg::ROLE_TABLE : sqltp_pkg::ROLE_NONE;
        end
        sqltp_pkg::S_UP_SET: begin
          s = (token_kind == sqltp_pkg::K_SET) ? sqltp_pkg::S_UP_FIELD : sqltp_pkg::S_FAIL;
        end
        sqltp_pkg::S_UP_FIELD: begin
          role = sqltp_pkg::ROLE_COLUMN;
          s    = sqltp_pkg::S_UP_EQ;
        end
        sqltp_pkg::S_UP_EQ: begin
          s = sqltp_pkg::S_UP_VALUE;
        end
        sqltp_pkg::S_UP_VALUE: begin
          role = sqltp_pkg::ROLE_VALUE;
          s    = sqltp_pkg::S_UP_SEP;
        end
        sqltp_pkg::S_UP_SEP: begin
          priority if (token_kind == sqltp_pkg::K_COMMA) begin
            s = sqltp_pkg::S_UP_FIELD;
          end else if (token_kind == sqltp_pkg::K_WHERE) begin
            s = sqltp_pkg::S_WH_FIELD;
          end else begin
            s = sqltp_pkg::S_FAIL;
          end
        end
        sqltp_pkg::S_SE_FIELD: begin
          priority if (token_kind == sqltp_pkg::K_STAR) begin
            role = sqltp_pkg::ROLE_COLUMN;
            s    = sqltp_pkg::S_SE_FROM;
          end else if (k_id) begin
            role = sqltp_pkg::ROLE_COLUMN;
            s    = (next_kind == sqltp_pkg::K_FROM) ? sqltp_pkg::S_SE_FROM
                                                    : sqltp_pkg::S_SE_COMMA;
          end else begin
            s = sqltp_pkg::S_FAIL;
          end
        end
        sqltp_pkg::S_SE_COMMA: begin
          s = (token_kind == sqltp_pkg::K_COMMA) ? sqltp_pkg::S_SE_FIELD : sqltp_pkg::S_FAIL;
        end
        sqltp_pkg::S_SE_FROM: begin
          s = (token_kind == sqltp_pkg::K_FROM) ? sqltp_pkg::S_SE_TABLE : sqltp_pkg::S_FAIL;
        end
        sqltp_pkg::S_SE_TABLE: begin
          priority if (!k_id) begin
            s = sqltp_pkg::S_FAIL;
          end else if (next_kind == sqltp_pkg::K_WHERE) begin
            role = sqltp_pkg::ROLE_TABLE;
            s    = sqltp_pkg::S_WH_KEYWORD;
          end else if (next_kind == sqltp_pkg::K_ORDER) begin
            role = sqltp_pkg::ROLE_TABLE;
            s    = sqltp_pkg::S_ORD;
          end else begin
            role = sqltp_pkg::ROLE_TABLE;
            s    = sqltp_pkg::S_DONE;
          end
        end
        sqltp_pkg::S_ORD: begin
          s = (token_kind == sqltp_pkg::K_ORDER) ? sqltp_pkg::S_ORD_BY : sqltp_pkg::S_FAIL;
        end
        sqltp_pkg::S_ORD_BY: begin
          s = (token_kind == sqltp_pkg::K_BY) ? sqltp_pkg::S_ORD_FIELD : sqltp_pkg::S_FAIL;
        end
        sqltp_pkg::S_ORD_FIELD: begin
          s    = k_id ? sqltp_pkg::S_DONE : sqltp_pkg::S_FAIL;
          role = k_id ? sqltp_pkg::ROLE_ORDER : sqltp_pkg::ROLE_NONE;
        end
        sqltp_pkg::S_WH_KEYWORD: begin
          s = sqltp_pkg::S_WH_FIELD;
        end
        sqltp_pkg::S_WH_FIELD: begin
          s    = k_id ? sqltp_pkg::S_WH_OP : sqltp_pkg::S_FAIL;
          role = k_id ? sqltp_pkg::ROLE_WH_FIELD : sqltp_pkg::ROLE_NONE;
        end
        sqltp_pkg::S_WH_OP: begin
          priority if (token_kind == sqltp_pkg::K_LESS) begin
            rel = sqltp_pkg::REL_LESS;
          end else if (token_kind == sqltp_pkg::K_GREATER) begin
            rel = sqltp_pkg::REL_GREATER;
          end else if (token_kind == sqltp_pkg::K_EQUAL) begin
            rel = sqltp_pkg::REL_EQUAL;
          end else begin
            rel = sqltp_pkg::REL_NONE;
          end
          if (rel != sqltp_pkg::REL_NONE) begin
            role = sqltp_pkg::ROLE_WH_OP;
            s    = sqltp_pkg::S_WH_VALUE;
          end else begin
            s = sqltp_pkg::S_FAIL;
          end
        end
        sqltp_pkg::S_WH_VALUE: begin
          if (k_id || token_kind == sqltp_pkg::K_NUMBER) begin
            role = sqltp_pkg::ROLE_WH_VALUE;
            s    = (next_kind == sqltp_pkg::K_ORDER) ? sqltp_pkg::S_ORD : sqltp_pkg::S_WH_AND;
          end else begin
            s = sqltp_pkg::S_FAIL;
          end
        end
        sqltp_pkg::S_WH_AND: begin
          s = sqltp_pkg::S_WH_FIELD;
        end
        sqltp_pkg::S_IN_INTO: begin
          s = (token_kind == sqltp_pkg::K_INTO) ? sqltp_pkg::S_IN_NAME : sqltp_pkg::S_FAIL;
        end
        sqltp_pkg::S_IN_NAME: begin
          s    = k_id ? sqltp_pkg::S_IN_LP : sqltp_pkg::S_FAIL;
          role = k_id ? sqltp_pkg::ROLE_TABLE : sqltp_pkg::ROLE_NONE;
        end
        sqltp_pkg::S_IN_LP: begin
          s = (token_kind == sqltp_pkg::K_LPAREN) ? sqltp_pkg::S_IN_FIELD : sqltp_pkg::S_FAIL;
        end
        sqltp_pkg::S_IN_FIELD: begin
          s    = k_id ? sqltp_pkg::S_IN_FSEP : sqltp_pkg::S_FAIL;
          role = k_id ? sqltp_pkg::ROLE_COLUMN : sqltp_pkg::ROLE_NONE;
        end
        sqltp_pkg::S_IN_FSEP: begin
          priority if (token_kind == sqltp_pkg::K_COMMA) begin
            s = sqltp_pkg::S_IN_FIELD;
          end else if (token_kind == sqltp_pkg::K_RPAREN) begin
            s = sqltp_pkg::S_IN_VKW;
          end else begin
            s = sqltp_pkg::S_FAIL;
          end
        end
        sqltp_pkg::S_IN_VKW: begin
          s = (token_kind == sqltp_pkg::K_VALUES) ? sqltp_pkg::S_IN_VLP : sqltp_pkg::S_FAIL;
        end
        sqltp_pkg::S_IN_VLP: begin
          s = (token_kind == sqltp_pkg::K_LPAREN) ? sqltp_pkg::S_IN_VAL : sqltp_pkg::S_FAIL;
        end
        sqltp_pkg::S_IN_VAL: begin
          if (k_id || token_kind == sqltp_pkg::K_STRING || token_kind == sqltp_pkg::K_NUMBER ||
              token_kind == sqltp_pkg::K_TRUE || token_kind == sqltp_pkg::K_FALSE) begin
            role = sqltp_pkg::ROLE_VALUE;
            s    = sqltp_pkg::S_IN_VSEP;
          end else begin
            s = sqltp_pkg::S_FAIL;
          end
        end
        sqltp_pkg::S_IN_VSEP: begin
          priority if (token_kind == sqltp_pkg::K_COMMA) begin
            s = (next_kind == sqltp_pkg::K_LPAREN) ? sqltp_pkg::S_IN_ROWLP
                                                   : sqltp_pkg::S_IN_VAL;
          end else if (token_kind == sqltp_pkg::K_RPAREN) begin
            s = sqltp_pkg::S_DONE;
          end else begin
            s = sqltp_pkg::S_FAIL;
          end
        end
        sqltp_pkg::S_IN_ROWLP: begin
          s = (token_kind == sqltp_pkg::K_LPAREN) ? sqltp_pkg::S_IN_VAL : sqltp_pkg::S_FAIL;
        end
        default: begin
          s = sqltp_pkg::S_FAIL;
        end
      endcase
      if (s == sqltp_pkg::S_DONE) begin
        status = sqltp_pkg::ST_OK;
      end else if (s == sqltp_pkg::S_FAIL) begin
        status = sqltp_pkg::ST_ERROR;
      end
    end
  end

  always_comb begin
    dec.step_next    = s;
    dec.qkind_next   = q;
    dec.token_role   = role;
    dec.relation_op  = rel;
    dec.query_kind   = (token_kind == sqltp_pkg::K_EOS) ? qkind : q;
    dec.parse_status = status;
  end

endmodule
